// File: hw/rtl/tsrp_pkg.sv
// Package for the round-robin / priority task scheduler.
// Holds sizes, command and mode codes, register indexes and the shared types.
// No dependencies.
package tsrp_pkg;

	localparam int MAX_TASKS = 16;
	localparam int IDLE_SLOT = 0;
	localparam int SLOT_W    = $clog2(MAX_TASKS);
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int PRIO_W    = 8;

	// command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_SCHED = 1'b1;

	// scheduler_mode codes
	localparam logic MODE_RR   = 1'b0;
	localparam logic MODE_PRIO = 1'b1;

	// register indexes (paddr[2])
	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	typedef struct packed {
		logic              command;
		logic [3:0]        slot_index;
		logic              slot_ready;
		logic [PRIO_W-1:0] slot_priority;
	} cmd_t;

	typedef struct packed {
		logic [3:0] next_task;
		logic       idle_chosen;
	} res_t;

	// slot table write request
	typedef struct packed {
		logic              en;
		logic [3:0]        idx;
		logic              ready;
		logic [PRIO_W-1:0] prio;
	} tbl_wr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_SCAN
	} state_t;

endpackage

// File: hw/rtl/tsrp_table.sv
// Task slot table: ready flag and priority per slot, cleared at reset.
// One write port, one read port. Depends on tsrp_pkg.
module tsrp_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tsrp_pkg::tbl_wr_t                   wr,
	input  logic [tsrp_pkg::SLOT_W-1:0]         rd_idx,
	output logic                                rd_ready,
	output logic [tsrp_pkg::PRIO_W-1:0]         rd_prio
);

	logic                        ready_q [tsrp_pkg::MAX_TASKS];
	logic [tsrp_pkg::PRIO_W-1:0] prio_q  [tsrp_pkg::MAX_TASKS];
	logic                        wr_hit;

	// slots beyond the table are dropped
	assign wr_hit = wr.en &&
		({{(tsrp_pkg::CNT_W-4){1'b0}}, wr.idx} < tsrp_pkg::CNT_W'(tsrp_pkg::MAX_TASKS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tsrp_pkg::MAX_TASKS; i++) begin
				ready_q[i] <= 1'b0;
				prio_q[i]  <= '0;
			end
		end else if (wr_hit) begin
			ready_q[wr.idx[tsrp_pkg::SLOT_W-1:0]] <= wr.ready;
			prio_q[wr.idx[tsrp_pkg::SLOT_W-1:0]]  <= wr.prio;
		end
	end

	assign rd_ready = ready_q[rd_idx];
	assign rd_prio  = prio_q[rd_idx];

endmodule

// File: hw/rtl/tsrp_seq.sv
// Scan sequencer: reduces the start slot modulo the count, then walks the
// table one slot a cycle through a shared compare. Depends on tsrp_pkg.
module tsrp_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                go,
	input  logic                                mode,
	input  logic [4:0]                          task_count,
	output logic [tsrp_pkg::SLOT_W-1:0]         rd_idx,
	input  logic                                rd_ready,
	input  logic [tsrp_pkg::PRIO_W-1:0]         rd_prio,
	output logic                                busy,
	output logic                                done,
	output tsrp_pkg::res_t                      result
);

	localparam int CW = tsrp_pkg::CNT_W;

	tsrp_pkg::state_t             state_q, state_n;
	logic [CW-1:0]                cnt_q, cnt_n;
	logic [CW-1:0]                pos_q, pos_n;
	logic [CW-1:0]                rem_q, rem_n;
	logic                         mode_q, mode_n;
	logic                         found_q, found_n;
	logic [tsrp_pkg::PRIO_W-1:0]  best_q, best_n;
	logic [tsrp_pkg::SLOT_W-1:0]  pick_q, pick_n;
	logic [tsrp_pkg::SLOT_W-1:0]  run_q, run_n;
	tsrp_pkg::res_t               res_q, res_n;
	logic                         done_q, done_n;
	logic [CW-1:0]                eff_cnt;
	logic [CW-1:0]                pos_inc;
	logic                         elig;
	logic [tsrp_pkg::PRIO_W-1:0]  key;
	logic                         take;
	logic                         fin_found;
	logic [tsrp_pkg::SLOT_W-1:0]  fin_pick;

	// count clamped to 1..MAX_TASKS
	always_comb begin
		priority if (task_count == 5'd0)
			eff_cnt = CW'(1);
		else if (int'(task_count) > tsrp_pkg::MAX_TASKS)
			eff_cnt = CW'(tsrp_pkg::MAX_TASKS);
		else
			eff_cnt = CW'(task_count);
	end

	assign rd_idx  = pos_q[tsrp_pkg::SLOT_W-1:0];
	assign pos_inc = pos_q + CW'(1);

	// shared compare: first strict maximum in circular order wins ties;
	// round-robin compares a constant key, so the first eligible slot wins
	assign elig = (rd_idx != tsrp_pkg::SLOT_W'(tsrp_pkg::IDLE_SLOT)) && rd_ready;
	assign key  = (mode_q == tsrp_pkg::MODE_PRIO) ? rd_prio : '0;
	assign take = elig && (!found_q || (key > best_q));
	assign fin_found = found_q || take;
	assign fin_pick  = take ? rd_idx : pick_q;

	always_comb begin
		state_n = state_q;
		cnt_n   = cnt_q;
		pos_n   = pos_q;
		rem_n   = rem_q;
		mode_n  = mode_q;
		found_n = found_q;
		best_n  = best_q;
		pick_n  = pick_q;
		run_n   = run_q;
		res_n   = res_q;
		done_n  = 1'b0;
		unique case (state_q)
			tsrp_pkg::ST_IDLE: begin
				if (go) begin
					cnt_n   = eff_cnt;
					rem_n   = eff_cnt;
					pos_n   = CW'(run_q) + CW'(1);
					mode_n  = mode;
					found_n = 1'b0;
					best_n  = '0;
					pick_n  = tsrp_pkg::SLOT_W'(tsrp_pkg::IDLE_SLOT);
					state_n = tsrp_pkg::ST_MOD;
				end
			end
			tsrp_pkg::ST_MOD: begin
				if (pos_q >= cnt_q)
					pos_n = pos_q - cnt_q;
				else
					state_n = tsrp_pkg::ST_SCAN;
			end
			tsrp_pkg::ST_SCAN: begin
				if (take) begin
					found_n = 1'b1;
					best_n  = key;
					pick_n  = rd_idx;
				end
				pos_n = (pos_inc == cnt_q) ? '0 : pos_inc;
				rem_n = rem_q - CW'(1);
				if (rem_q == CW'(1)) begin
					run_n             = fin_found ? fin_pick
						: tsrp_pkg::SLOT_W'(tsrp_pkg::IDLE_SLOT);
					res_n.next_task   = 4'(run_n);
					res_n.idle_chosen = !fin_found;
					done_n            = 1'b1;
					state_n           = tsrp_pkg::ST_IDLE;
				end
			end
			default: state_n = tsrp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsrp_pkg::ST_IDLE;
			run_q   <= tsrp_pkg::SLOT_W'(tsrp_pkg::IDLE_SLOT);
			done_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_n;
			run_q   <= run_n;
			done_q  <= done_n;
			found_q <= found_n;
		end
	end

	always_ff @(posedge clk) begin
		cnt_q  <= cnt_n;
		pos_q  <= pos_n;
		rem_q  <= rem_n;
		mode_q <= mode_n;
		best_q <= best_n;
		pick_q <= pick_n;
		res_q  <= res_n;
	end

	assign busy   = (state_q != tsrp_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

// File: hw/rtl/task_scheduler_rr_priority.sv
// Top level of the round-robin / priority task scheduler.
// Holds the APB registers and ties the slot table to the scan sequencer.
// Depends on tsrp_pkg, tsrp_table, tsrp_seq.

// Usage: a command transfer is taken on a clock edge with start high and
// busy low. A write command updates one task slot in that cycle, produces
// no result and leaves busy low, so a new command may follow at once. A
// schedule command raises busy and runs the shared compare over the slot
// table one slot per cycle; the chosen slot appears on result with done high
// for exactly one cycle, and the receiver cannot stall it, so it must take
// the transfer in that cycle. Busy covers the subtract steps that wrap the
// scan's start slot, q = floor((running + 1) / N) of them, then a step into
// the scan, then the scan over N slots, where N is the task count clamped to
// 1..16. Busy drops in the cycle done is high, so the next command may be
// taken alongside the result. Slot 0 is the idle task: it is never picked
// as an ordinary task and is reported with idle_chosen when no other slot
// below the task count is ready. Registers: 0x0 scheduler_mode (bit 0),
// 0x4 task_count (bits 4:0); write them only while busy is low.
module task_scheduler_rr_priority (
	input  logic                clk,
	input  logic                arst_n,
	// command channel
	input  logic                start,
	output logic                busy,
	input  tsrp_pkg::cmd_t      cmd,
	// result channel
	output logic                done,
	output tsrp_pkg::res_t      result,
	// APB configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic                        mode_q;
	logic [4:0]                  count_q;
	logic                        cfg_wr;
	logic                        cmd_take;
	tsrp_pkg::tbl_wr_t           tbl_wr;
	logic                        seq_go;
	logic [tsrp_pkg::SLOT_W-1:0] rd_idx;
	logic                        rd_ready;
	logic [tsrp_pkg::PRIO_W-1:0] rd_prio;

	// ---------------- configuration registers ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// register index is paddr[2]; low address bits are not decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= tsrp_pkg::MODE_RR;
			count_q <= 5'd1;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				tsrp_pkg::REG_MODE:  mode_q  <= pwdata[0];
				tsrp_pkg::REG_COUNT: count_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			tsrp_pkg::REG_MODE:  prdata = {31'd0, mode_q};
			tsrp_pkg::REG_COUNT: prdata = {27'd0, count_q};
			default:             prdata = '0;
		endcase
	end

	// ---------------- command decode ----------------
	// a transfer is taken whenever start meets busy low
	assign cmd_take = start && !busy;

	// slot writes go straight to the table in the transfer cycle
	assign tbl_wr.en    = cmd_take && (cmd.command == tsrp_pkg::CMD_WRITE);
	assign tbl_wr.idx   = cmd.slot_index;
	assign tbl_wr.ready = cmd.slot_ready;
	assign tbl_wr.prio  = cmd.slot_priority;

	// schedule commands kick off the scan
	assign seq_go = cmd_take && (cmd.command == tsrp_pkg::CMD_SCHED);

	// ---------------- slot table ----------------
	tsrp_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (tbl_wr),
		.rd_idx   (rd_idx),
		.rd_ready (rd_ready),
		.rd_prio  (rd_prio)
	);

	// ---------------- scan sequencer ----------------
	// holds the running slot; one table slot compared per cycle
	tsrp_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (seq_go),
		.mode       (mode_q),
		.task_count (count_q),
		.rd_idx     (rd_idx),
		.rd_ready   (rd_ready),
		.rd_prio    (rd_prio),
		.busy       (busy),
		.done       (done),
		.result     (result)
	);

endmodule
